// ===== hdl/hpd_pkg.sv =====
// Shared types and constants for the Huffman pixel decoder.
package hpd_pkg;

  // Input function codes
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_DATA  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  // Configuration register indexes
  localparam logic CFG_GRAY_MODE   = 1'b0;
  localparam logic CFG_IMAGE_WIDTH = 1'b1;

  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned POS_W      = 12;
  localparam logic [12:0] POS_MAX    = 13'd4095;

  // Entries reduced per group in the first match stage
  localparam int unsigned GROUP_SIZE = 16;
  localparam int unsigned GROUP_IW   = 4;

  localparam logic [1:0] CHAN_RED   = 2'd0;
  localparam logic [1:0] CHAN_GREEN = 2'd1;
  localparam logic [1:0] CHAN_BLUE  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_RES,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic load_entry;
    logic start_image;
    logic start_byte;
    logic resolve;
    logic last_bit;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic hit_pixel;
    logic pend_valid;
    logic can_push;
  } status_t;

endpackage

// ===== hdl/hpd_code_cam.sv =====
// Code table cells with a registered first-level match reduction per group.
module hpd_code_cam #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned KEY_BITS      = 32,
  localparam int unsigned SYM_W        = $clog2(TABLE_ENTRIES),
  localparam int unsigned N_GROUPS     =
    (TABLE_ENTRIES + hpd_pkg::GROUP_SIZE - 1) / hpd_pkg::GROUP_SIZE
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [SYM_W-1:0]         wr_idx_i,
  input  logic [KEY_BITS-1:0]      wr_key_i,
  input  logic                     clear_i,
  input  logic [KEY_BITS-1:0]      key_i,
  output logic [N_GROUPS-1:0]      grp_hit_o,
  output logic [hpd_pkg::GROUP_IW-1:0] grp_idx_o [N_GROUPS]
);

  localparam int unsigned PAD_ENTRIES = N_GROUPS * hpd_pkg::GROUP_SIZE;

  logic [KEY_BITS-1:0]      cell_key_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] cell_valid_q;
  logic [PAD_ENTRIES-1:0]   match;
  logic [N_GROUPS-1:0]      grp_hit_d, grp_hit_q;
  logic [hpd_pkg::GROUP_IW-1:0] grp_idx_d [N_GROUPS];
  logic [hpd_pkg::GROUP_IW-1:0] grp_idx_q [N_GROUPS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      cell_key_q[wr_idx_i] <= wr_key_i;
    end
  end

  // A zero key never matches, so a cell only counts once it holds a nonzero key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_valid_q <= '0;
    end else if (clear_i) begin
      cell_valid_q <= '0;
    end else if (wr_en_i) begin
      cell_valid_q[wr_idx_i] <= (wr_key_i != '0);
    end
  end

  for (genvar e = 0; e < PAD_ENTRIES; e++) begin : g_match
    if (e < TABLE_ENTRIES) begin : g_cell
      assign match[e] = cell_valid_q[e] && (cell_key_q[e] == key_i);
    end else begin : g_pad
      assign match[e] = 1'b0;
    end
  end

  // Lowest matching entry within each group wins
  always_comb begin
    for (int g = 0; g < N_GROUPS; g++) begin
      grp_hit_d[g] = |match[g*hpd_pkg::GROUP_SIZE +: hpd_pkg::GROUP_SIZE];
      grp_idx_d[g] = '0;
      for (int j = hpd_pkg::GROUP_SIZE - 1; j >= 0; j--) begin
        if (match[g*hpd_pkg::GROUP_SIZE + j]) begin
          grp_idx_d[g] = hpd_pkg::GROUP_IW'(j);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_hit_q <= '0;
    end else begin
      grp_hit_q <= grp_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_idx_q <= grp_idx_d;
  end

  assign grp_hit_o = grp_hit_q;
  assign grp_idx_o = grp_idx_q;

endmodule

// ===== hdl/hpd_datapath.sv =====
// Key shifter, symbol resolve, pixel assembly, position counters and output registers.
module hpd_datapath #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned KEY_BITS      = 32,
  parameter int unsigned MAX_WIDTH     = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  hpd_pkg::cmd_t                  cmd_i,
  output hpd_pkg::status_t               status_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [hpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [7:0]                     entry_symbol_i,
  input  logic [31:0]                    entry_key_i,
  input  logic [7:0]                     data_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     red_o,
  output logic [7:0]                     green_o,
  output logic [7:0]                     blue_o,
  output logic [hpd_pkg::POS_W-1:0]      column_o,
  output logic [hpd_pkg::POS_W-1:0]      row_index_o,
  output logic                           last_o
);

  localparam int unsigned SYM_W    = $clog2(TABLE_ENTRIES);
  localparam int unsigned N_GROUPS =
    (TABLE_ENTRIES + hpd_pkg::GROUP_SIZE - 1) / hpd_pkg::GROUP_SIZE;
  localparam int unsigned NG_W     = (N_GROUPS > 1) ? $clog2(N_GROUPS) : 1;
  localparam int unsigned WLOG     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WCMP_W   = (WLOG > hpd_pkg::CFG_DATA_W) ? WLOG
                                                                 : hpd_pkg::CFG_DATA_W;

  // Configuration
  logic                           gray_mode_q;
  logic [hpd_pkg::CFG_DATA_W-1:0] image_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gray_mode_q   <= 1'b0;
      image_width_q <= hpd_pkg::CFG_DATA_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hpd_pkg::CFG_GRAY_MODE:   gray_mode_q   <= cfg_data_i[0];
        hpd_pkg::CFG_IMAGE_WIDTH: image_width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Code table
  logic [N_GROUPS-1:0]          grp_hit;
  logic [hpd_pkg::GROUP_IW-1:0] grp_idx [N_GROUPS];
  logic [KEY_BITS-1:0]          key_d, key_q;
  logic                         wr_en;

  assign wr_en = cmd_i.load_entry && ({1'b0, entry_symbol_i} < 9'(TABLE_ENTRIES));

  hpd_code_cam #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BITS      (KEY_BITS)
  ) u_cam (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_idx_i  (entry_symbol_i[SYM_W-1:0]),
    .wr_key_i  (entry_key_i[KEY_BITS-1:0]),
    .clear_i   (cmd_i.start_image),
    .key_i     (key_q),
    .grp_hit_o (grp_hit),
    .grp_idx_o (grp_idx)
  );

  // Second match level: lowest hitting group
  logic                        hit;
  logic [NG_W-1:0]             sel_grp;
  logic [NG_W+hpd_pkg::GROUP_IW-1:0] sym_full;
  logic [7:0]                  sym;

  always_comb begin
    sel_grp = '0;
    for (int g = N_GROUPS - 1; g >= 0; g--) begin
      if (grp_hit[g]) begin
        sel_grp = NG_W'(g);
      end
    end
  end

  assign hit      = |grp_hit;
  assign sym_full = {sel_grp, grp_idx[sel_grp]};
  assign sym      = 8'(sym_full);

  // Decode state
  logic [7:0]               byte_sh_d, byte_sh_q;
  logic [1:0]               chan_d, chan_q;
  logic [7:0]               red_hold_d, red_hold_q;
  logic [7:0]               green_hold_d, green_hold_q;
  logic [hpd_pkg::POS_W-1:0] col_d, col_q;
  logic [hpd_pkg::POS_W-1:0] row_d, row_q;
  logic [KEY_BITS-1:0]      key_base;
  logic                     hit_pixel;
  logic                     new_pix;
  logic [7:0]               pix_r, pix_g, pix_b;

  // Pending pixel and output register
  logic                     pend_v_d, pend_v_q;
  logic [7:0]               pend_r_d, pend_r_q, pend_g_d, pend_g_q, pend_b_d, pend_b_q;
  logic [hpd_pkg::POS_W-1:0] pend_col_d, pend_col_q, pend_row_d, pend_row_q;
  logic                     out_v_d, out_v_q;
  logic [7:0]               out_r_d, out_r_q, out_g_d, out_g_q, out_b_d, out_b_q;
  logic [hpd_pkg::POS_W-1:0] out_col_d, out_col_q, out_row_d, out_row_q;
  logic                     out_last_d, out_last_q;
  logic                     can_push;

  // Effective width and column wrap
  logic [WCMP_W-1:0]        w_raw, w_eff;
  logic [hpd_pkg::POS_W:0]  col_next;
  logic                     col_wrap;

  assign w_raw    = WCMP_W'(image_width_q);
  assign w_eff    = (w_raw == '0) ? WCMP_W'(1)
                  : (w_raw > WCMP_W'(MAX_WIDTH)) ? WCMP_W'(MAX_WIDTH) : w_raw;
  assign col_next = {1'b0, col_q} + 13'd1;
  assign col_wrap = (WCMP_W'(col_next) >= w_eff) || (col_next > hpd_pkg::POS_MAX);

  assign hit_pixel = hit && (gray_mode_q || chan_q[1]);
  assign new_pix   = cmd_i.resolve && hit_pixel;
  assign key_base  = hit ? KEY_BITS'(1) : key_q;
  assign can_push  = !out_v_q || !out_stall_i;

  assign pix_r = gray_mode_q ? sym : red_hold_q;
  assign pix_g = gray_mode_q ? sym : green_hold_q;
  assign pix_b = sym;

  always_comb begin
    key_d        = key_q;
    byte_sh_d    = byte_sh_q;
    chan_d       = chan_q;
    red_hold_d   = red_hold_q;
    green_hold_d = green_hold_q;
    col_d        = col_q;
    row_d        = row_q;

    if (cmd_i.start_image) begin
      key_d        = KEY_BITS'(1);
      chan_d       = hpd_pkg::CHAN_RED;
      red_hold_d   = '0;
      green_hold_d = '0;
      col_d        = '0;
      row_d        = '0;
    end else if (cmd_i.start_byte) begin
      key_d     = {key_q[KEY_BITS-2:0], data_byte_i[7]};
      byte_sh_d = {data_byte_i[6:0], 1'b0};
    end else if (cmd_i.resolve) begin
      if (cmd_i.last_bit) begin
        key_d = key_base;
      end else begin
        key_d     = {key_base[KEY_BITS-2:0], byte_sh_q[7]};
        byte_sh_d = {byte_sh_q[6:0], 1'b0};
      end
      if (hit) begin
        if (gray_mode_q) begin
          chan_d = hpd_pkg::CHAN_RED;
        end else begin
          case (chan_q)
            hpd_pkg::CHAN_RED: begin
              red_hold_d = sym;
              chan_d     = hpd_pkg::CHAN_GREEN;
            end
            hpd_pkg::CHAN_GREEN: begin
              green_hold_d = sym;
              chan_d       = hpd_pkg::CHAN_BLUE;
            end
            default: chan_d = hpd_pkg::CHAN_RED;
          endcase
        end
      end
      if (new_pix) begin
        if (col_wrap) begin
          col_d = '0;
          if (row_q != hpd_pkg::POS_W'(hpd_pkg::POS_MAX)) begin
            row_d = row_q + 12'd1;
          end
        end else begin
          col_d = col_next[hpd_pkg::POS_W-1:0];
        end
      end
    end
  end

  always_comb begin
    pend_v_d   = pend_v_q;
    pend_r_d   = pend_r_q;
    pend_g_d   = pend_g_q;
    pend_b_d   = pend_b_q;
    pend_col_d = pend_col_q;
    pend_row_d = pend_row_q;
    out_v_d    = out_v_q && out_stall_i;
    out_r_d    = out_r_q;
    out_g_d    = out_g_q;
    out_b_d    = out_b_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_last_d = out_last_q;

    // A pending pixel moves out when another one arrives (not last) or at flush (last)
    if ((new_pix && pend_v_q) || cmd_i.flush) begin
      out_v_d    = 1'b1;
      out_r_d    = pend_r_q;
      out_g_d    = pend_g_q;
      out_b_d    = pend_b_q;
      out_col_d  = pend_col_q;
      out_row_d  = pend_row_q;
      out_last_d = cmd_i.flush;
    end
    if (cmd_i.flush) begin
      pend_v_d = 1'b0;
    end
    if (new_pix) begin
      pend_v_d   = 1'b1;
      pend_r_d   = pix_r;
      pend_g_d   = pix_g;
      pend_b_d   = pix_b;
      pend_col_d = col_q;
      pend_row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q        <= KEY_BITS'(1);
      chan_q       <= hpd_pkg::CHAN_RED;
      red_hold_q   <= '0;
      green_hold_q <= '0;
      col_q        <= '0;
      row_q        <= '0;
      pend_v_q     <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      key_q        <= key_d;
      chan_q       <= chan_d;
      red_hold_q   <= red_hold_d;
      green_hold_q <= green_hold_d;
      col_q        <= col_d;
      row_q        <= row_d;
      pend_v_q     <= pend_v_d;
      out_v_q      <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_sh_q  <= byte_sh_d;
    pend_r_q   <= pend_r_d;
    pend_g_q   <= pend_g_d;
    pend_b_q   <= pend_b_d;
    pend_col_q <= pend_col_d;
    pend_row_q <= pend_row_d;
    out_r_q    <= out_r_d;
    out_g_q    <= out_g_d;
    out_b_q    <= out_b_d;
    out_col_q  <= out_col_d;
    out_row_q  <= out_row_d;
    out_last_q <= out_last_d;
  end

  assign status_o.hit_pixel  = hit_pixel;
  assign status_o.pend_valid = pend_v_q;
  assign status_o.can_push   = can_push;

  assign out_valid_o = out_v_q;
  assign red_o       = out_r_q;
  assign green_o     = out_g_q;
  assign blue_o      = out_b_q;
  assign column_o    = out_col_q;
  assign row_index_o = out_row_q;
  assign last_o      = out_last_q;

endmodule

// ===== hdl/hpd_ctrl.sv =====
// Sequencing state machine: a compare state and a resolve state per coded bit.
module hpd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       func_i,
  input  hpd_pkg::status_t status_i,
  output hpd_pkg::cmd_t    cmd_o
);

  hpd_pkg::state_e state_d, state_q;
  logic [2:0]      bit_cnt_d, bit_cnt_q;
  logic            res_wait;
  logic            last_bit;

  // A new pixel cannot enter while the pending one has nowhere to go
  assign res_wait = status_i.hit_pixel && status_i.pend_valid && !status_i.can_push;
  assign last_bit = (bit_cnt_q == 3'd7);

  always_comb begin
    state_d   = state_q;
    bit_cnt_d = bit_cnt_q;
    case (state_q)
      hpd_pkg::ST_IDLE: begin
        if (in_valid_i && (func_i == hpd_pkg::FUNC_DATA)) begin
          state_d   = hpd_pkg::ST_CMP;
          bit_cnt_d = '0;
        end
      end
      hpd_pkg::ST_CMP: state_d = hpd_pkg::ST_RES;
      hpd_pkg::ST_RES: begin
        if (!res_wait) begin
          if (last_bit) begin
            state_d = hpd_pkg::ST_FLUSH;
          end else begin
            state_d   = hpd_pkg::ST_CMP;
            bit_cnt_d = bit_cnt_q + 3'd1;
          end
        end
      end
      hpd_pkg::ST_FLUSH: begin
        if (!status_i.pend_valid || status_i.can_push) begin
          state_d = hpd_pkg::ST_IDLE;
        end
      end
      default: state_d = hpd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      hpd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_entry  = (func_i == hpd_pkg::FUNC_LOAD);
          cmd_o.start_image = (func_i == hpd_pkg::FUNC_START);
          cmd_o.start_byte  = (func_i == hpd_pkg::FUNC_DATA);
        end
      end
      hpd_pkg::ST_RES: begin
        cmd_o.resolve  = !res_wait;
        cmd_o.last_bit = last_bit;
      end
      hpd_pkg::ST_FLUSH: begin
        cmd_o.flush = status_i.pend_valid && status_i.can_push;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hpd_pkg::ST_IDLE;
      bit_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
    end
  end

endmodule

// ===== hdl/huffman_pixel_decoder_unit.sv =====
// Huffman pixel decoder top level: controller plus datapath.
//
// Table loads and start-image commands are taken in the idle state. A data byte
// is one transfer, then per coded bit a compare state (every table cell checks
// the key and each group of 16 cells picks its lowest hit into a register) and a
// resolve state (picks the lowest hitting group and updates key, channels and
// position), then a flush state that releases the byte's final pixel with last
// set. A stalled output can hold the resolve and flush states. Pixels leave
// through an output register, so the next item is taken while the last result
// still waits. Start image clears the whole table.
module huffman_pixel_decoder_unit #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned KEY_BITS      = 32,
  parameter int unsigned MAX_WIDTH     = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [hpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     func_i,
  input  logic [7:0]                     entry_symbol_i,
  input  logic [31:0]                    entry_key_i,
  input  logic [7:0]                     data_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     red_o,
  output logic [7:0]                     green_o,
  output logic [7:0]                     blue_o,
  output logic [hpd_pkg::POS_W-1:0]      column_o,
  output logic [hpd_pkg::POS_W-1:0]      row_index_o,
  output logic                           last_o
);

  hpd_pkg::cmd_t    cmd;
  hpd_pkg::status_t status;

  hpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hpd_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BITS      (KEY_BITS),
    .MAX_WIDTH     (MAX_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .entry_symbol_i (entry_symbol_i),
    .entry_key_i    (entry_key_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .column_o       (column_o),
    .row_index_o    (row_index_o),
    .last_o         (last_o)
  );

endmodule

// ===== tb/hpd_pixel_checker.sv =====
`timescale 1ns / 100ps
// Pixel checker: watches the input, config and pixel channels, predicts pixels and compares.
module hpd_pixel_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [hpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [1:0]                     func_i,
  input  logic [7:0]                     entry_symbol_i,
  input  logic [31:0]                    entry_key_i,
  input  logic [7:0]                     data_byte_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [7:0]                     red_i,
  input  logic [7:0]                     green_i,
  input  logic [7:0]                     blue_i,
  input  logic [hpd_pkg::POS_W-1:0]      column_i,
  input  logic [hpd_pkg::POS_W-1:0]      row_index_i,
  input  logic                           last_i,
  output int                             fail_cnt_o,
  output int                             pending_o
);

  localparam int unsigned                    SYMBOLS  = 256;
  localparam logic [hpd_pkg::CFG_DATA_W-1:0] MAX_COLS = 13'd4096;

  typedef struct packed {
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;
    logic [hpd_pkg::POS_W-1:0] column;
    logic [hpd_pkg::POS_W-1:0] row;
    logic                      last;
  } pixel_t;

  logic [31:0]                    code_tbl [SYMBOLS];
  logic [31:0]                    key_q;
  logic [1:0]                     chan_cnt;
  logic [7:0]                     red_hold;
  logic [7:0]                     green_hold;
  logic [hpd_pkg::POS_W-1:0]      col_q;
  logic [hpd_pkg::POS_W-1:0]      row_q;
  logic                           gray_q;
  logic [hpd_pkg::CFG_DATA_W-1:0] width_q;
  pixel_t                         pixel_q [$];

  task automatic clear_image();
    foreach (code_tbl[s]) code_tbl[s] = '0;
    key_q      = 32'd1;
    chan_cnt   = hpd_pkg::CHAN_RED;
    red_hold   = '0;
    green_hold = '0;
    col_q      = '0;
    row_q      = '0;
  endtask

  task automatic place_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    logic [hpd_pkg::CFG_DATA_W-1:0] w;
    logic [hpd_pkg::CFG_DATA_W-1:0] next_col;
    pixel_t                         p;
    w = width_q;
    if (w == '0) w = 13'd1;
    if (w > MAX_COLS) w = MAX_COLS;
    p = '{red: r, green: g, blue: b, column: col_q, row: row_q, last: 1'b0};
    pixel_q.insert(pixel_q.size(), p);
    next_col = {1'b0, col_q} + 13'd1;
    if (next_col >= w || next_col > hpd_pkg::POS_MAX) begin
      col_q = '0;
      if ({1'b0, row_q} < hpd_pkg::POS_MAX) row_q = row_q + 12'd1;
    end else begin
      col_q = next_col[hpd_pkg::POS_W-1:0];
    end
  endtask

  task automatic decode_byte(input logic [7:0] data);
    int     b;
    int     s;
    int     hit;
    int     first;
    int     last_idx;
    pixel_t p;
    first = pixel_q.size();
    for (b = 7; b >= 0; b--) begin
      key_q = {key_q[30:0], data[b]};
      hit = -1;
      // an unused entry holds zero, so a zero key never hits
      if (key_q != '0) begin
        for (s = 0; s < SYMBOLS && hit < 0; s++)
          if (code_tbl[s] == key_q) hit = s;
      end
      if (hit >= 0) begin
        key_q = 32'd1;
        if (gray_q) begin
          chan_cnt = hpd_pkg::CHAN_RED;
          place_pixel(8'(hit), 8'(hit), 8'(hit));
        end else if (chan_cnt == hpd_pkg::CHAN_RED) begin
          red_hold = 8'(hit);
          chan_cnt = hpd_pkg::CHAN_GREEN;
        end else if (chan_cnt == hpd_pkg::CHAN_GREEN) begin
          green_hold = 8'(hit);
          chan_cnt = hpd_pkg::CHAN_BLUE;
        end else begin
          chan_cnt = hpd_pkg::CHAN_RED;
          place_pixel(red_hold, green_hold, 8'(hit));
        end
      end
    end
    if (pixel_q.size() > first) begin
      last_idx = pixel_q.size() - 1;
      p = pixel_q[last_idx];
      p.last = 1'b1;
      pixel_q[last_idx] = p;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      clear_image();
      gray_q     = 1'b0;
      width_q    = 13'd1;
      fail_cnt_o = 0;
      pixel_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pixel_q.size() == 0) begin
          $error("pixel transfer with none expected: rgb %0d/%0d/%0d at %0d,%0d",
                 red_i, green_i, blue_i, column_i, row_index_i);
          fail_cnt_o++;
        end else begin
          want = pixel_q.pop_front();
          check_field("red", 32'(want.red), 32'(red_i));
          check_field("green", 32'(want.green), 32'(green_i));
          check_field("blue", 32'(want.blue), 32'(blue_i));
          check_field("column", 32'(want.column), 32'(column_i));
          check_field("row_index", 32'(want.row), 32'(row_index_i));
          check_field("last", 32'(want.last), 32'(last_i));
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == hpd_pkg::CFG_GRAY_MODE) gray_q = cfg_data_i[0];
        else                                       width_q = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        case (func_i)
          hpd_pkg::FUNC_LOAD:  code_tbl[entry_symbol_i] = entry_key_i;
          hpd_pkg::FUNC_DATA:  decode_byte(data_byte_i);
          hpd_pkg::FUNC_START: clear_image();
          default:             ;
        endcase
      end
    end
    pending_o = pixel_q.size();
  end

endmodule

// ===== tb/tb_huffman_pixel_decoder_unit.sv =====
`timescale 1ns / 100ps
// Testbench top for the Huffman pixel decoder: clock, reset, stimulus and verdict.
module tb_huffman_pixel_decoder_unit;

  localparam logic [1:0] FUNC_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS  = 180;
  localparam int         STRIP_BYTES   = 40;
  localparam int         SETTLE_CYCLES = 40;

  logic                           clk_i          = 1'b0;
  logic                           rst_ni         = 1'b0;
  logic                           cfg_we_i       = 1'b0;
  logic                           cfg_index_i    = 1'b0;
  logic [hpd_pkg::CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                           in_valid_i     = 1'b0;
  logic                           in_stall_o;
  logic [1:0]                     func_i         = hpd_pkg::FUNC_START;
  logic [7:0]                     entry_symbol_i = '0;
  logic [31:0]                    entry_key_i    = '0;
  logic [7:0]                     data_byte_i    = '0;
  logic                           out_valid_o;
  logic                           out_stall_i    = 1'b0;
  logic [7:0]                     red_o;
  logic [7:0]                     green_o;
  logic [7:0]                     blue_o;
  logic [hpd_pkg::POS_W-1:0]      column_o;
  logic [hpd_pkg::POS_W-1:0]      row_index_o;
  logic                           last_o;

  logic calm = 1'b0;
  int   fail_cnt;
  int   pixels_pending;
  int   items_sent = 0;

  // prefix code currently loaded: symbol, code bits and code length per leaf
  logic [7:0]  code_sym  [$];
  logic [31:0] code_bits [$];
  int          code_len  [$];
  bit          bit_q     [$];

  huffman_pixel_decoder_unit DUT (.*);

  hpd_pixel_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_i     (in_stall_o),
    .func_i,
    .entry_symbol_i,
    .entry_key_i,
    .data_byte_i,
    .out_valid_i    (out_valid_o),
    .out_stall_i,
    .red_i          (red_o),
    .green_i        (green_o),
    .blue_i         (blue_o),
    .column_i       (column_o),
    .row_index_i    (row_index_o),
    .last_i         (last_o),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pixels_pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 9);
  end

  task automatic send_item(input logic [1:0] func, input logic [7:0] sym,
                           input logic [31:0] key, input logic [7:0] data_val);
    @(negedge clk_i);
    if (!calm && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= func;
    entry_symbol_i <= sym;
    entry_key_i    <= key;
    data_byte_i    <= data_val;
    do @(posedge clk_i); while (in_stall_o);
    if (func != FUNC_UNUSED) items_sent++;
  endtask

  // drop valid, wait for every pixel, then let a byte without pixels finish
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pixels_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [hpd_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random complete prefix code: split random leaves, then assign canonical codes.
  task automatic load_prefix_code(input int n, input int max_depth);
    int          depth_q [$];
    int          perm [256];
    int          i;
    int          j;
    int          idx;
    int          tmp;
    logic [31:0] code;
    code_sym.delete();
    code_bits.delete();
    code_len.delete();
    for (i = 0; i < 256; i++) perm[i] = i;
    for (i = 255; i > 0; i--) begin
      j       = $urandom_range(i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    depth_q.insert(0, 0);
    while (depth_q.size() < n) begin
      idx = $urandom_range(depth_q.size() - 1);
      if (depth_q[idx] < max_depth) begin
        depth_q[idx]++;
        depth_q.insert(depth_q.size(), depth_q[idx]);
      end
    end
    depth_q.sort();
    code = '0;
    for (i = 0; i < n; i++) begin
      if (i > 0) code = (code + 1) << (depth_q[i] - depth_q[i-1]);
      code_sym.insert(code_sym.size(), 8'(perm[i]));
      code_bits.insert(code_bits.size(), code);
      code_len.insert(code_len.size(), depth_q[i]);
    end
    for (i = 0; i < n; i++)
      send_item(hpd_pkg::FUNC_LOAD, code_sym[i], (32'd1 << code_len[i]) | code_bits[i],
                8'($urandom));
  endtask

  task automatic send_noise();
    case ($urandom_range(7))
      0, 1:    send_item(FUNC_UNUSED, 8'($urandom), $urandom, 8'($urandom));
      2, 3:    send_item(hpd_pkg::FUNC_LOAD, 8'($urandom),
                         ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom), 8'($urandom));
      4, 5, 6: send_item(hpd_pkg::FUNC_DATA, 8'($urandom), $urandom, 8'($urandom));
      default: send_item(hpd_pkg::FUNC_START, 8'($urandom), $urandom, 8'($urandom));
    endcase
  endtask

  // Encode random symbols of the loaded code into bytes, with some noise between.
  task automatic send_stream(input int n_bytes);
    int         sent;
    int         k;
    int         b;
    logic [7:0] val;
    sent = 0;
    val  = '0;
    bit_q.delete();
    while (sent < n_bytes) begin
      while (bit_q.size() < 8) begin
        k = $urandom_range(code_sym.size() - 1);
        for (b = code_len[k] - 1; b >= 0; b--) bit_q.insert(bit_q.size(), code_bits[k][b]);
      end
      for (b = 0; b < 8; b++) val = {val[6:0], bit_q.pop_front()};
      send_item(hpd_pkg::FUNC_DATA, 8'($urandom), $urandom, val);
      sent++;
      if ($urandom_range(99) < 12) send_noise();
    end
    // a partial code left over goes out padded with random trailing bits
    if (bit_q.size() != 0) begin
      val = 8'($urandom);
      for (b = 7; b >= 0 && bit_q.size() != 0; b--) val[b] = bit_q.pop_front();
      send_item(hpd_pkg::FUNC_DATA, 8'($urandom), $urandom, val);
    end
    bit_q.delete();
  endtask

  initial begin
    int                             base;
    int                             phase;
    logic [hpd_pkg::CFG_DATA_W-1:0] w;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // gray mode, two-bit codes, narrow rows
    write_cfg(hpd_pkg::CFG_GRAY_MODE, 13'd1);
    write_cfg(hpd_pkg::CFG_IMAGE_WIDTH, 13'd3);
    send_item(hpd_pkg::FUNC_START, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    send_item(hpd_pkg::FUNC_LOAD, 8'hFF, 32'h0000_0006, 8'h00);
    send_item(hpd_pkg::FUNC_LOAD, 8'h00, 32'h0000_0007, 8'hFF);
    send_item(hpd_pkg::FUNC_LOAD, 8'h5A, 32'h0000_0004, 8'h00);
    // same key as symbol FF: the lower symbol must win
    send_item(hpd_pkg::FUNC_LOAD, 8'hA5, 32'h0000_0006, 8'h00);
    send_item(hpd_pkg::FUNC_DATA, 8'h00, 32'h0000_0000, 8'hB2);
    send_item(hpd_pkg::FUNC_DATA, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    send_item(hpd_pkg::FUNC_DATA, 8'h00, 32'h0000_0000, 8'h00);
    send_item(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF, 8'hFF);

    // 32 zero bits push the key down to zero, which must not hit an empty entry;
    // the next 32 bits lose the marker and match a full-width key
    send_item(hpd_pkg::FUNC_START, 8'h00, 32'h0000_0000, 8'h00);
    send_item(hpd_pkg::FUNC_LOAD, 8'h81, 32'hDEAD_BEEF, 8'h00);
    repeat (4) send_item(hpd_pkg::FUNC_DATA, 8'h00, 32'h0000_0000, 8'h00);
    send_item(hpd_pkg::FUNC_DATA, 8'h00, 32'h0000_0000, 8'hDE);
    send_item(hpd_pkg::FUNC_DATA, 8'h00, 32'h0000_0000, 8'hAD);
    send_item(hpd_pkg::FUNC_DATA, 8'h00, 32'h0000_0000, 8'hBE);
    send_item(hpd_pkg::FUNC_DATA, 8'h00, 32'h0000_0000, 8'hEF);

    // colour mode, width above the maximum, one-bit codes; leave a red channel held
    drain();
    write_cfg(hpd_pkg::CFG_GRAY_MODE, 13'd0);
    write_cfg(hpd_pkg::CFG_IMAGE_WIDTH, 13'd8191);
    send_item(hpd_pkg::FUNC_START, 8'h00, 32'h0000_0000, 8'h00);
    send_item(hpd_pkg::FUNC_LOAD, 8'h12, 32'h0000_0002, 8'h00);
    send_item(hpd_pkg::FUNC_LOAD, 8'hED, 32'h0000_0003, 8'h00);
    send_item(hpd_pkg::FUNC_DATA, 8'h00, 32'h0000_0000, 8'h5B);
    send_item(hpd_pkg::FUNC_DATA, 8'h00, 32'h0000_0000, 8'hC4);
    // switching to gray drops the held channel
    drain();
    write_cfg(hpd_pkg::CFG_GRAY_MODE, 13'd1);
    send_item(hpd_pkg::FUNC_DATA, 8'h00, 32'h0000_0000, 8'h3A);

    // one pixel per row, every bit a symbol: eight pixels and rows per byte
    drain();
    write_cfg(hpd_pkg::CFG_IMAGE_WIDTH, 13'd1);
    repeat (STRIP_BYTES) send_item(hpd_pkg::FUNC_DATA, 8'($urandom), $urandom, 8'($urandom));

    base  = items_sent;
    phase = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      drain();
      calm = (phase == 1);
      write_cfg(hpd_pkg::CFG_GRAY_MODE, 13'($urandom_range(1)));
      case ($urandom_range(7))
        0:       w = 13'd0;
        1:       w = 13'd1;
        2:       w = 13'd4096;
        3:       w = 13'd8191;
        4:       w = 13'($urandom_range(4097, 8190));
        default: w = 13'($urandom_range(2, 12));
      endcase
      write_cfg(hpd_pkg::CFG_IMAGE_WIDTH, w);
      if ($urandom_range(7) != 0)
        send_item(hpd_pkg::FUNC_START, 8'($urandom), $urandom, 8'($urandom));
      load_prefix_code($urandom_range(2, 24), ($urandom_range(3) == 0) ? 24 : 8);
      send_stream($urandom_range(8, 24));
      phase++;
    end
    calm = 1'b0;

    drain();
    if (fail_cnt == 0) $display("SUCCESS");
    else               $display("FAILURE");
    $finish;
  end

  // hard stop at 1 ms, far beyond the slowest correct run
  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

endmodule
